// ----- rtl/core/rbsp_exp_golomb_bit_reader_defines.svh -----
// Assertion macros for the RBSP Exp-Golomb bit reader checker.
// Expects aclk and aresetn in the scope where a macro is used.
`ifndef RBSP_EXP_GOLOMB_BIT_READER_DEFINES_SVH
`define RBSP_EXP_GOLOMB_BIT_READER_DEFINES_SVH

// Checked only while out of reset
`define RBSP_EG_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Checked on every edge, reset included
`define RBSP_EG_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- rtl/core/rbsp_eg_pkg.sv -----
// Shared types and constants for the RBSP Exp-Golomb bit reader.
// No dependencies; used by the top level and its checker.
package rbsp_eg_pkg;

    localparam int MODE_W      = 3;
    localparam int STATUS_W    = 2;
    localparam int VALUE_W     = 33;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 40;
    localparam int MAX_READ    = 32;
    localparam logic [7:0] BYTE_EPB  = 8'h03;
    localparam logic [1:0] ZRUN_MAX  = 2'd2;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH  = 3'd0,
        MODE_BITS  = 3'd1,
        MODE_UE    = 3'd2,
        MODE_SE    = 3'd3,
        MODE_ALIGN = 3'd4
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_SHORT = 2'd1,
        ST_LONG  = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef struct packed {
        mode_t       mode;
        logic [7:0]  data_byte;
        logic        last_byte;
        logic [5:0]  bit_count;
    } item_t;

endpackage

// ----- rtl/core/rbsp_exp_golomb_bit_reader.sv -----
// RBSP bit reader: emulation prevention removal, MSB-first bit window,
// fixed-width reads, ue/se Exp-Golomb decode and byte alignment.
// Depends on rbsp_eg_pkg.
// Each input beat passes through the input register, then the result register.
// Throughput: one beat per cycle while the result output is not stalled; the bit window,
// count and phase update once per item in a single pass, which sets the rate.
// Reset (aresetn low, synchronous): window, counts, escape and end-of-stream
// state, rbsp_enable and both valid flags cleared.
module rbsp_exp_golomb_bit_reader #(
    parameter int STORE_BITS = 64,
    parameter int MAX_PREFIX = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic                                 cfg_wdata,      // rbsp_enable
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [rbsp_eg_pkg::S_TDATA_W-1:0]    s_axis_tdata,   // data_byte[7:0], bit_count[13:8]
    input  logic [rbsp_eg_pkg::MODE_W-1:0]       s_axis_tuser,   // mode[2:0]
    input  logic                                 s_axis_tlast,   // last_byte
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [rbsp_eg_pkg::M_TDATA_W-1:0]    m_axis_tdata,   // value[32:0] (signed)
    output logic [rbsp_eg_pkg::STATUS_W-1:0]     m_axis_tuser    // status[1:0]
);

    localparam int SLOTS  = STORE_BITS / 8;
    localparam int HELD_W = $clog2(STORE_BITS + 1);
    localparam int SUM_W  = HELD_W + 1;
    localparam int LIMIT  = MAX_PREFIX + 1;
    localparam int LZ_W   = $clog2(LIMIT + 1);
    localparam int CODE_W = 2 * MAX_PREFIX + 1;
    localparam int CW     = (CODE_W > rbsp_eg_pkg::VALUE_W) ? CODE_W : rbsp_eg_pkg::VALUE_W;
    localparam int EXT_W  = STORE_BITS + CODE_W;
    localparam int CONS_W = $clog2(((CODE_W > rbsp_eg_pkg::MAX_READ) ? CODE_W
                                    : rbsp_eg_pkg::MAX_READ) + 1);
    localparam int CMP_W  = HELD_W + LZ_W + 1;
    localparam int VW     = rbsp_eg_pkg::VALUE_W;

    // input stage
    logic                 item_valid_reg;
    rbsp_eg_pkg::item_t   item_reg;
    rbsp_eg_pkg::item_t   item_next;
    logic                 advance;

    // bit reader state
    logic [STORE_BITS-1:0] win_reg, win_next;
    logic [HELD_W-1:0]     held_reg, held_next;
    logic [2:0]            phase_reg, phase_next;
    logic [1:0]            zrun_reg, zrun_next;
    logic                  esc_reg, esc_next;
    logic                  ended_reg, ended_next;
    logic                  rbsp_en_reg;

    // result stage
    logic                  out_valid_reg;
    logic [VW-1:0]         out_value_reg;
    rbsp_eg_pkg::status_t  out_status_reg;
    logic [VW-1:0]         res_value;
    rbsp_eg_pkg::status_t  res_status;

    // datapath
    logic [LZ_W-1:0]       lead;
    logic [LZ_W:0]         ue_len;
    logic                  long_pf, ue_short;
    logic [EXT_W-1:0]      ext;
    logic [CODE_W-1:0]     topc;
    logic [CONS_W-1:0]     shamt;
    logic [CW-1:0]         code_full, half, se_val;
    logic [VW-1:0]         top_bits, rd_val;
    logic [5:0]            cnt, rd_n;
    logic [2:0]            align_r;
    logic [SUM_W-1:0]      used;
    logic [1:0]            need;
    logic                  full, need_none;
    logic [15:0]           pv;
    logic [4:0]            plen;
    logic [STORE_BITS-1:0] ins;
    logic [CONS_W-1:0]     cons;
    logic                  take;

    assign advance       = item_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !item_valid_reg || advance;

    always_comb begin
        item_next.mode      = rbsp_eg_pkg::mode_t'(s_axis_tuser);
        item_next.data_byte = s_axis_tdata[7:0];
        item_next.last_byte = s_axis_tlast;
        item_next.bit_count = s_axis_tdata[13:8];
    end

    // leading zero count over the first LIMIT window bits
    always_comb begin
        lead = LZ_W'(LIMIT);
        for (int i = LIMIT - 1; i >= 0; i--) begin
            if (win_reg[STORE_BITS-1-i]) begin
                lead = LZ_W'(i);
            end
        end
    end

    always_comb begin
        ue_len   = {lead, 1'b1};
        long_pf  = (lead == LZ_W'(LIMIT)) && (CMP_W'(held_reg) >= CMP_W'(LIMIT));
        ue_short = (CMP_W'(lead) >= CMP_W'(held_reg)) ||
                   (CMP_W'(held_reg) < CMP_W'(ue_len));
        ext      = {win_reg, {CODE_W{1'b0}}};
        topc     = ext[EXT_W-1 -: CODE_W];
        shamt    = (lead < LZ_W'(LIMIT)) ? (CONS_W'(CODE_W) - CONS_W'(ue_len)) : '0;
        code_full = CW'(topc >> shamt) - CW'(1);
        half     = code_full >> 1;
        se_val   = code_full[0] ? (half + CW'(1)) : (~half + CW'(1));

        cnt      = (item_reg.bit_count > 6'(rbsp_eg_pkg::MAX_READ)) ?
                   6'(rbsp_eg_pkg::MAX_READ) : item_reg.bit_count;
        align_r  = 3'd0 - phase_reg;
        rd_n     = (item_reg.mode == rbsp_eg_pkg::MODE_ALIGN) ? {3'd0, align_r} : cnt;
        top_bits = win_reg[STORE_BITS-1 -: VW];
        rd_val   = top_bits >> (6'(VW) - rd_n);
    end

    // push capacity and insertion
    always_comb begin
        used      = (SUM_W'(phase_reg) + SUM_W'(held_reg)) >> 3;
        need_none = !esc_reg && rbsp_en_reg && (item_reg.data_byte == rbsp_eg_pkg::BYTE_EPB)
                    && (zrun_reg >= rbsp_eg_pkg::ZRUN_MAX) && !item_reg.last_byte;
        if (esc_reg && (item_reg.data_byte > rbsp_eg_pkg::BYTE_EPB)) begin
            need = 2'd2;
            pv   = {rbsp_eg_pkg::BYTE_EPB, item_reg.data_byte};
            plen = 5'd16;
        end else begin
            need = need_none ? 2'd0 : 2'd1;
            pv   = {item_reg.data_byte, 8'h00};
            plen = 5'd8;
        end
        full = (used + SUM_W'(need)) > SUM_W'(SLOTS);
        ins  = {pv, {(STORE_BITS-16){1'b0}}} >> held_reg;
    end

    always_comb begin
        win_next   = win_reg;
        held_next  = held_reg;
        phase_next = phase_reg;
        zrun_next  = zrun_reg;
        esc_next   = esc_reg;
        ended_next = ended_reg;
        res_value  = '0;
        res_status = rbsp_eg_pkg::ST_OK;
        cons       = '0;
        take       = 1'b0;
        unique case (item_reg.mode)
            rbsp_eg_pkg::MODE_PUSH: begin
                if (!ended_reg) begin
                    if (full) begin
                        res_status = rbsp_eg_pkg::ST_FULL;
                    end else begin
                        if (esc_reg) begin
                            win_next  = win_reg | ins;
                            held_next = held_reg + HELD_W'(plen);
                            esc_next  = 1'b0;
                            zrun_next = (item_reg.data_byte == 8'h00) ? 2'd1 : 2'd0;
                        end else if (need_none) begin
                            esc_next  = 1'b1;
                            zrun_next = 2'd0;
                        end else begin
                            win_next  = win_reg | ins;
                            held_next = held_reg + HELD_W'(plen);
                            if (item_reg.data_byte != 8'h00) begin
                                zrun_next = 2'd0;
                            end else if (zrun_reg != rbsp_eg_pkg::ZRUN_MAX) begin
                                zrun_next = zrun_reg + 2'd1;
                            end
                        end
                        if (item_reg.last_byte) begin
                            ended_next = 1'b1;
                        end
                    end
                end
            end
            rbsp_eg_pkg::MODE_BITS: begin
                if (cnt != 6'd0) begin
                    if (CMP_W'(held_reg) < CMP_W'(cnt)) begin
                        res_status = rbsp_eg_pkg::ST_SHORT;
                    end else begin
                        res_value = rd_val;
                        cons      = CONS_W'(cnt);
                        take      = 1'b1;
                    end
                end
            end
            rbsp_eg_pkg::MODE_UE, rbsp_eg_pkg::MODE_SE: begin
                if (long_pf) begin
                    res_status = rbsp_eg_pkg::ST_LONG;
                end else if (ue_short) begin
                    res_status = rbsp_eg_pkg::ST_SHORT;
                end else begin
                    res_value = (item_reg.mode == rbsp_eg_pkg::MODE_SE) ?
                                se_val[VW-1:0] : code_full[VW-1:0];
                    cons      = CONS_W'(ue_len);
                    take      = 1'b1;
                end
            end
            rbsp_eg_pkg::MODE_ALIGN: begin
                if (align_r != 3'd0) begin
                    if (CMP_W'(held_reg) < CMP_W'(align_r)) begin
                        res_status = rbsp_eg_pkg::ST_SHORT;
                    end else begin
                        res_value = rd_val;
                        cons      = CONS_W'(align_r);
                        take      = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        if (take) begin
            win_next   = win_reg << cons;
            held_next  = held_reg - HELD_W'(cons);
            phase_next = phase_reg + cons[2:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            rbsp_en_reg    <= 1'b0;
            win_reg        <= '0;
            held_reg       <= '0;
            phase_reg      <= '0;
            zrun_reg       <= '0;
            esc_reg        <= 1'b0;
            ended_reg      <= 1'b0;
        end else begin
            if (cfg_we) begin
                rbsp_en_reg <= cfg_wdata;
            end
            if (s_axis_tready) begin
                item_valid_reg <= s_axis_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                win_reg       <= win_next;
                held_reg      <= held_next;
                phase_reg     <= phase_next;
                zrun_reg      <= zrun_next;
                esc_reg       <= esc_next;
                ended_reg     <= ended_next;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            item_reg <= item_next;
        end
        if (advance) begin
            out_value_reg  <= res_value;
            out_status_reg <= res_status;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(rbsp_eg_pkg::M_TDATA_W-VW){1'b0}}, out_value_reg};
    assign m_axis_tuser  = out_status_reg;

endmodule

// ----- rtl/core/rbsp_eg_checker.sv -----
// Port-level checks for the RBSP Exp-Golomb bit reader, bound to the top level.
// Depends on rbsp_eg_pkg and rbsp_exp_golomb_bit_reader_defines.svh.
`include "rbsp_exp_golomb_bit_reader_defines.svh"
module rbsp_eg_checker (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 s_axis_tvalid,
    input logic                                 s_axis_tready,
    input logic                                 m_axis_tvalid,
    input logic                                 m_axis_tready,
    input logic [rbsp_eg_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    input logic [rbsp_eg_pkg::STATUS_W-1:0]     m_axis_tuser
);

    `RBSP_EG_ASSERT_RST(a_rst_no_beat, !aresetn |=> !m_axis_tvalid, "result beat straight after reset")
    `RBSP_EG_ASSERT(a_err_zero, m_axis_tvalid && (m_axis_tuser != rbsp_eg_pkg::ST_OK) |-> m_axis_tdata == '0, "non-zero value with error status")
    `RBSP_EG_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result beat changed")
    `RBSP_EG_ASSERT(a_in_ready, !m_axis_tvalid |-> s_axis_tready, "input stalled with empty output")

endmodule

bind rbsp_exp_golomb_bit_reader rbsp_eg_checker u_rbsp_eg_checker (.*);

// ----- dv/tb_rbsp_exp_golomb_bit_reader.sv -----
// Self-checking bench for rbsp_exp_golomb_bit_reader: payload bytes and read commands in,
// one result beat out per input beat, compared against an in-bench bit reader model.
// Depends on rbsp_eg_pkg and the RTL top level only.
module tb_rbsp_exp_golomb_bit_reader;
    import rbsp_eg_pkg::*;

    localparam int STORE_BITS  = 64;
    localparam int MAX_PREFIX  = 16;
    localparam int SLOTS       = STORE_BITS / 8;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 250;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        status_t            status;
    } result_t;

    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 cfg_we        = 1'b0;
    logic                 cfg_wdata     = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic [MODE_W-1:0]    s_axis_tuser  = '0;
    logic                 s_axis_tlast  = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [STATUS_W-1:0]  m_axis_tuser;

    // Bit window model plus the queue of results still owed by the block
    class reader_scoreboard;
        bit              rbsp_on;
        bit [7:0]        slot [SLOTS];
        int unsigned     held;
        int unsigned     phase;
        int unsigned     zrun;
        bit              esc_held;
        bit              ended;
        result_t         due [$];
        int              errors;

        function new();
            rbsp_on  = 0;
            foreach (slot[k]) slot[k] = 8'h00;
            held     = 0;
            phase    = 0;
            zrun     = 0;
            esc_held = 0;
            ended    = 0;
            errors   = 0;
        endfunction

        function int unsigned used_slots();
            return (phase + held) >> 3;
        endfunction

        function bit bit_at(int unsigned i);
            int unsigned p;
            p = phase + i;
            if ((p >> 3) >= SLOTS) return 1'b0;
            return slot[p >> 3][7 - (p & 7)];
        endfunction

        function logic [63:0] take(int unsigned n);
            logic [63:0] v;
            int unsigned p;
            int unsigned sh;
            v = '0;
            for (int unsigned i = 0; i < n; i++) v = {v[62:0], bit_at(i)};
            p  = phase + n;
            sh = p >> 3;
            if (sh > SLOTS) sh = SLOTS;
            for (int unsigned k = 0; k < SLOTS; k++)
                slot[k] = (k + sh < SLOTS) ? slot[k + sh] : 8'h00;
            phase = p & 7;
            held  = held - n;
            return v;
        endfunction

        function void append(logic [7:0] b);
            int unsigned u;
            u = used_slots();
            if (u < SLOTS) begin
                slot[u] = b;
                held    = held + 8;
            end
        endfunction

        function status_t push(logic [7:0] b, logic last);
            int unsigned need;
            if (ended) return ST_OK;
            if (esc_held)
                need = (b <= BYTE_EPB) ? 1 : 2;
            else if (rbsp_on && b == BYTE_EPB && zrun >= ZRUN_MAX && !last)
                need = 0;
            else
                need = 1;
            if (used_slots() + need > SLOTS) return ST_FULL;
            if (esc_held) begin
                if (b > BYTE_EPB) append(BYTE_EPB);
                append(b);
                esc_held = 0;
                zrun     = (b == 8'h00) ? 1 : 0;
            end else if (need == 0) begin
                esc_held = 1;
                zrun     = 0;
            end else begin
                append(b);
                zrun = (b == 8'h00) ? ((zrun >= ZRUN_MAX) ? ZRUN_MAX : zrun + 1) : 0;
            end
            if (last) ended = 1;
            return ST_OK;
        endfunction

        function status_t golomb(output logic [63:0] code);
            int unsigned lz;
            code = '0;
            lz   = 0;
            while (lz < MAX_PREFIX + 1 && lz < held && !bit_at(lz)) lz++;
            if (lz >= MAX_PREFIX + 1) return ST_LONG;
            if (lz >= held) return ST_SHORT;
            if (held < 2 * lz + 1) return ST_SHORT;
            void'(take(lz + 1));
            code = (64'd1 << lz) - 64'd1 + take(lz);
            return ST_OK;
        endfunction

        function void apply_item(item_t it);
            result_t     r;
            logic [63:0] code;
            logic [63:0] t;
            int unsigned cnt;
            r.value  = '0;
            r.status = ST_OK;
            case (it.mode)
                MODE_PUSH: r.status = push(it.data_byte, it.last_byte);
                MODE_BITS: begin
                    cnt = (it.bit_count > MAX_READ) ? MAX_READ : it.bit_count;
                    if (cnt != 0) begin
                        if (held < cnt) r.status = ST_SHORT;
                        else begin
                            t       = take(cnt);
                            r.value = t[VALUE_W-1:0];
                        end
                    end
                end
                MODE_UE: begin
                    r.status = golomb(code);
                    if (r.status == ST_OK) r.value = code[VALUE_W-1:0];
                end
                MODE_SE: begin
                    r.status = golomb(code);
                    if (r.status == ST_OK) begin
                        t       = code[0] ? (code >> 1) + 64'd1 : 64'd0 - (code >> 1);
                        r.value = t[VALUE_W-1:0];
                    end
                end
                MODE_ALIGN: begin
                    cnt = (8 - phase) & 7;
                    if (cnt != 0) begin
                        if (held < cnt) r.status = ST_SHORT;
                        else begin
                            t       = take(cnt);
                            r.value = t[VALUE_W-1:0];
                        end
                    end
                end
                default: ;
            endcase
            due.push_back(r);
        endfunction

        function void check_beat(logic [VALUE_W-1:0] value, logic [STATUS_W-1:0] status);
            result_t e;
            if (due.size() == 0) begin
                $error("result beat with nothing outstanding: value %0h status %0d",
                       value, status);
                errors++;
                return;
            end
            e = due.pop_front();
            if (value !== e.value) begin
                $error("value: expected %0h, got %0h", e.value, value);
                errors++;
            end
            if (status !== e.status) begin
                $error("status: expected %0d, got %0d", e.status, status);
                errors++;
            end
        endfunction
    endclass

    reader_scoreboard sb = new();
    int unsigned      burst_left  = 0;
    int unsigned      ready_left  = 0;
    int unsigned      ready_style = 0;
    int unsigned      cycle_no    = 0;

    rbsp_exp_golomb_bit_reader #(
        .STORE_BITS(STORE_BITS),
        .MAX_PREFIX(MAX_PREFIX)
    ) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_no++;
        if (cycle_no > CYCLE_LIMIT) begin
            $display("rbsp_exp_golomb_bit_reader: mismatch");
            $finish;
        end
    end

    // Receiver back-pressure: style is redrawn whenever its random run counter expires
    always @(posedge aclk) begin
        if (ready_left == 0) begin
            ready_style = $urandom_range(3);
            ready_left  = $urandom_range(256, 32);
        end
        ready_left--;
        case (ready_style)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= 1'($urandom_range(1));
            2:       m_axis_tready <= ($urandom_range(3) == 0);
            default: m_axis_tready <= (ready_left % 5 != 0);
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready)
            sb.check_beat(m_axis_tdata[VALUE_W-1:0], m_axis_tuser);
    end

    function automatic item_t pack_item(logic [2:0] m, logic [7:0] d, logic l, logic [5:0] c);
        return {m, d, l, c};
    endfunction

    // Payload biased towards zero runs and escape bytes
    function automatic logic [7:0] rand_payload();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 30) return 8'h00;
        if (r < 45) return BYTE_EPB;
        if (r < 55) return 8'($urandom_range(2));
        return 8'($urandom);
    endfunction

    function automatic item_t rand_command();
        int unsigned r;
        logic [2:0]  m;
        logic [5:0]  c;
        r = $urandom_range(99);
        if (r < 50)      m = MODE_BITS;
        else if (r < 70) m = MODE_UE;
        else if (r < 85) m = MODE_SE;
        else if (r < 95) m = MODE_ALIGN;
        else             m = 3'($urandom_range(7, 5));
        r = $urandom_range(99);
        if (r < 60)      c = 6'($urandom_range(8, 1));
        else if (r < 85) c = 6'($urandom_range(32, 9));
        else if (r < 95) c = 6'($urandom_range(63, 33));
        else             c = 6'd0;
        return pack_item(m, 8'($urandom), 1'($urandom), c);
    endfunction

    task automatic drive_item(item_t it);
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge aclk);
            burst_left = ($urandom_range(9) == 0) ? $urandom_range(300, 100)
                                                  : $urandom_range(24, 1);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.mode;
        s_axis_tdata  <= {2'b00, it.bit_count, it.data_byte};
        s_axis_tlast  <= it.last_byte;
        do @(posedge aclk); while (!s_axis_tready);
        burst_left--;
        sb.apply_item(it);
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (sb.due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_rbsp_enable(bit v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        sb.rbsp_on = v;
    endtask

    task automatic push(logic [7:0] b, logic l);
        drive_item(pack_item(MODE_PUSH, b, l, 6'($urandom)));
    endtask

    task automatic command(logic [2:0] m, logic [5:0] c);
        drive_item(pack_item(m, 8'($urandom), 1'b0, c));
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_rbsp_enable(1'b1);

        // reads and an undefined mode on an empty window
        command(MODE_BITS, 6'd1);
        command(MODE_UE, 6'd0);
        command(MODE_ALIGN, 6'd0);
        drive_item(pack_item(3'd7, 8'hFF, 1'b1, 6'd63));
        // dropped escape, then a kept one, then fill to the brim
        push(8'h00, 1'b0);
        push(8'h00, 1'b0);
        push(BYTE_EPB, 1'b0);
        push(8'h01, 1'b0);
        push(8'h00, 1'b0);
        push(8'h00, 1'b0);
        push(BYTE_EPB, 1'b0);
        push(8'hFF, 1'b0);
        push(8'h80, 1'b0);
        push(8'h55, 1'b0);
        command(MODE_UE, 6'd0);
        command(MODE_BITS, 6'd0);
        command(MODE_BITS, 6'd63);
        command(MODE_BITS, 6'd1);
        command(MODE_ALIGN, 6'd0);
        command(MODE_UE, 6'd0);
        command(MODE_BITS, 6'd8);
        command(MODE_SE, 6'd0);
        command(MODE_UE, 6'd0);
        command(MODE_BITS, 6'd10);
        // escape left pending across a switch to pass-through
        push(8'h00, 1'b0);
        push(8'h00, 1'b0);
        push(BYTE_EPB, 1'b0);
        settle();
        write_rbsp_enable(1'b0);
        push(8'h02, 1'b0);

        for (int ph = 0; ph < PHASES; ph++) begin
            int unsigned done;
            int unsigned chunk;
            int unsigned push_pct;
            settle();
            write_rbsp_enable(!sb.rbsp_on);
            done = 0;
            while (done < PHASE_ITEMS) begin
                chunk = $urandom_range(40, 8);
                case ($urandom_range(2))
                    0:       push_pct = 25;
                    1:       push_pct = 55;
                    default: push_pct = 85;
                endcase
                for (int unsigned i = 0; i < chunk && done < PHASE_ITEMS; i++) begin
                    if ($urandom_range(99) < push_pct) push(rand_payload(), 1'b0);
                    else drive_item(rand_command());
                    done++;
                end
            end
        end

        // end of stream: a trailing 0x03 after two zeros is kept
        settle();
        write_rbsp_enable(1'b1);
        while (sb.held >= 32) command(MODE_BITS, 6'd32);
        if (sb.held != 0) command(MODE_BITS, 6'(sb.held));
        push(8'h00, 1'b0);
        push(8'h00, 1'b0);
        push(BYTE_EPB, 1'b1);
        push(8'h04, 1'b0);
        command(MODE_BITS, 6'd24);
        command(MODE_UE, 6'd0);
        settle();

        if (sb.errors == 0 && sb.due.size() == 0)
            $display("rbsp_exp_golomb_bit_reader: match");
        else
            $display("rbsp_exp_golomb_bit_reader: mismatch");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/rbsp_eg_pkg.sv
rtl/core/rbsp_exp_golomb_bit_reader.sv
rtl/core/rbsp_eg_checker.sv
dv/tb_rbsp_exp_golomb_bit_reader.sv
